/* hdl/ekt_pkg.sv */
// package for the expiring key table: transaction structs, opcodes, status codes
// no dependencies
`default_nettype none
package ekt_pkg;

  localparam int unsigned TableEntriesDefault = 256;
  localparam int unsigned KeyBytesDefault     = 16;

  localparam logic [31:0] AllFeeds  = 32'hA11FEED5;
  localparam logic [15:0] SvcPrefix = 16'h2600;
  localparam logic [15:0] SvcOldLow = 16'h0001;
  localparam logic [31:0] Low16Mask = 32'h0000FFFF;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_EXACT  = 3'd1,
    OP_LOW16  = 3'd2,
    OP_SVC    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADLN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  entry_type;
    logic [31:0] provider;
    logic [7:0]  key_idx;
    logic [15:0] service_id;
    logic [26:0] expiry;
    logic [26:0] today;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  found_length;
    logic [63:0] found_low;
    logic [63:0] found_high;
  } rsp_t;

  // slot layout in memory
  typedef struct packed {
    logic [2:0]  stype;
    logic [31:0] prov;
    logic [7:0]  idx;
    logic [26:0] exp;
    logic [63:0] klo;
    logic [63:0] khi;
    logic [4:0]  len;
  } slot_t;

  function automatic logic [63:0] low_mask(input logic [4:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (5'(b) < len) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [63:0] high_mask(input logic [4:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (5'(b + 8) < len) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* hdl/ekt_ram.sv */
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none
module ekt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* hdl/ekt_ctrl.sv */
// walk sequencer for the expiring key table
// depends on ekt_pkg and ekt_ram
`default_nettype none
module ekt_ctrl #(
  parameter int unsigned TableEntries = ekt_pkg::TableEntriesDefault,
  parameter int unsigned KeyBytes     = ekt_pkg::KeyBytesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire ekt_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output ekt_pkg::rsp_t      rsp_o
);
  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] Full = CW'(TableEntries);
  localparam logic [4:0] MaxLen = 5'(KeyBytes);

  ekt_pkg::state_e state_q, state_d;
  ekt_pkg::req_t   req_q, req_d;
  ekt_pkg::rsp_t   rsp_q, rsp_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ptr_q, ptr_d;     // insert: ascending index; lookups: remaining
  logic [1:0]      cand_q, cand_d;
  logic            done_q, done_d;

  logic            we;
  logic [AW-1:0]   addr;
  ekt_pkg::slot_t  wslot, rslot;

  ekt_ram #(.Width($bits(ekt_pkg::slot_t)), .Depth(TableEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wslot),
    .rdata_o (rslot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ekt_pkg::S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    ptr_q  <= ptr_d;
    cand_q <= cand_d;
  end

  logic [31:0] cprov, pmask, want_prov;
  logic [2:0]  want_type;
  logic [7:0]  want_idx;
  logic        live, hit, is_svc;

  always_comb begin
    unique case (cand_q)
      2'd0:    cprov = {ekt_pkg::SvcPrefix, req_q.service_id};
      2'd1:    cprov = {req_q.service_id, ekt_pkg::SvcOldLow};
      2'd2:    cprov = {16'h0000, req_q.service_id};
      default: cprov = ekt_pkg::AllFeeds;
    endcase
    is_svc    = req_q.opcode == ekt_pkg::OP_SVC;
    pmask     = (req_q.opcode == ekt_pkg::OP_LOW16) ? ekt_pkg::Low16Mask : '1;
    want_prov = is_svc ? cprov : req_q.provider;
    want_type = is_svc ? 3'd0 : req_q.entry_type;
    want_idx  = is_svc ? 8'd0 : req_q.key_idx;
    live      = (rslot.exp == '0) || (req_q.today <= rslot.exp);
    hit       = (rslot.stype == want_type) && (rslot.idx == want_idx)
                && ((rslot.prov & pmask) == (want_prov & pmask));
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    rsp_d   = rsp_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    cand_d  = cand_q;
    done_d  = 1'b0;
    we      = 1'b0;
    addr    = ptr_q[AW-1:0];
    wslot.stype = req_q.entry_type;
    wslot.prov  = req_q.provider;
    wslot.idx   = req_q.key_idx;
    wslot.exp   = req_q.expiry;
    wslot.klo   = req_q.key_low & ekt_pkg::low_mask(req_q.key_length);
    wslot.khi   = req_q.key_high & ekt_pkg::high_mask(req_q.key_length);
    wslot.len   = req_q.key_length;

    unique case (state_q)
      ekt_pkg::S_IDLE: begin
        if (start_i) begin
          req_d  = req_i;
          rsp_d  = '{status: ekt_pkg::ST_MISS, default: '0};
          cand_d = '0;
          state_d = ekt_pkg::S_DONE;
          unique case (req_i.opcode)
            ekt_pkg::OP_INSERT: begin
              if (count_q >= Full) rsp_d.status = ekt_pkg::ST_FULL;
              else if (req_i.key_length == '0 || req_i.key_length > MaxLen)
                rsp_d.status = ekt_pkg::ST_BADLN;
              else begin
                ptr_d = '0;
                state_d = ekt_pkg::S_ISSUE;
              end
            end
            ekt_pkg::OP_EXACT, ekt_pkg::OP_LOW16, ekt_pkg::OP_SVC: begin
              ptr_d = count_q;
              state_d = ekt_pkg::S_ISSUE;
            end
            ekt_pkg::OP_CLEAR: begin
              count_d = '0;
              rsp_d.status = ekt_pkg::ST_OK;
            end
            default: ;
          endcase
        end
      end
      ekt_pkg::S_ISSUE: begin
        if (req_q.opcode == ekt_pkg::OP_INSERT) begin
          if (ptr_q == count_q) begin
            state_d = ekt_pkg::S_WRITE;
          end else begin
            state_d = ekt_pkg::S_CHECK;
          end
        end else if (ptr_q == '0) begin
          if (is_svc && cand_q != 2'd3) begin
            cand_d = cand_q + 2'd1;
            ptr_d  = count_q;
          end else begin
            state_d = ekt_pkg::S_DONE;
          end
        end else begin
          ptr_d = ptr_q - CW'(1);
          addr  = ptr_d[AW-1:0];
          state_d = ekt_pkg::S_CHECK;
        end
      end
      ekt_pkg::S_CHECK: begin
        state_d = ekt_pkg::S_ISSUE;
        if (req_q.opcode == ekt_pkg::OP_INSERT) begin
          if (rslot.stype == req_q.entry_type && rslot.prov == req_q.provider
              && rslot.idx == req_q.key_idx)
            state_d = ekt_pkg::S_WRITE;
          else
            ptr_d = ptr_q + CW'(1);
        end else if (hit && live) begin
          if (!is_svc) begin
            rsp_d = '{status: ekt_pkg::ST_OK, found_length: rslot.len,
                      found_low: rslot.klo, found_high: rslot.khi};
            state_d = ekt_pkg::S_DONE;
          end else if (rslot.len == 5'd8 || rslot.len == 5'd16) begin
            rsp_d = '{status: ekt_pkg::ST_OK, found_length: 5'd16,
                      found_low: rslot.klo, found_high: rslot.klo};
            state_d = ekt_pkg::S_DONE;
          end else begin
            ptr_d = '0;
          end
        end
      end
      ekt_pkg::S_WRITE: begin
        we = 1'b1;
        if (ptr_q == count_q) count_d = count_q + CW'(1);
        rsp_d.status = ekt_pkg::ST_OK;
        state_d = ekt_pkg::S_DONE;
      end
      ekt_pkg::S_DONE: begin
        done_d  = 1'b1;
        state_d = ekt_pkg::S_IDLE;
      end
      default: state_d = ekt_pkg::S_IDLE;
    endcase
  end

  assign busy_o = state_q != ekt_pkg::S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule
`default_nettype wire

/* hdl/expiring_key_table.sv */
// top level of the expiring key table
// depends on ekt_pkg and ekt_ctrl
// one transaction is taken per start while busy is low; its result is strobed on done_o for
// exactly one cycle and the receiver cannot stall. slots sit in one ram and are checked one
// at a time, each read issued and then checked. a lookup walks newest first; service lookup
// repeats the walk for up to four providers; insert scans oldest first. clear, unused
// opcodes and refused inserts go straight to the done state without a walk. busy drops in
// the result cycle, so the next start can be taken there.
`default_nettype none
module expiring_key_table #(
  parameter int unsigned TableEntries = ekt_pkg::TableEntriesDefault,
  parameter int unsigned KeyBytes     = ekt_pkg::KeyBytesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire ekt_pkg::req_t req_i,
  output logic               busy,
  output logic               done_o,
  output ekt_pkg::rsp_t      rsp_o
);
  ekt_ctrl #(.TableEntries(TableEntries), .KeyBytes(KeyBytes)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );
endmodule
`default_nettype wire
